/* rtl/rgb_hsv_color_classifier_unit_defines.svh */
// Assertion macros for the RGB to HSV color classifier.
// Used by rgb_hsv_color_classifier_unit; expects clk and arst_n in scope.
`ifndef RGB_HSV_COLOR_CLASSIFIER_UNIT_DEFINES_SVH
`define RGB_HSV_COLOR_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication
`define RHCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RHCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rhcc_pkg.sv */
// Shared types, constants and helpers of the RGB to HSV color classifier.
// No dependencies; imported by every rhcc module and the top level.
package rhcc_pkg;

	localparam int RAW_BITS_DEF  = 10;
	localparam int QUO_BITS      = 11;
	localparam int HUE_BITS      = 14;
	localparam int SAT_BITS      = 11;
	localparam int VAL_BITS      = 7;
	localparam int CLS_BITS      = 3;
	localparam int REF_SAT_BITS  = 7;
	localparam int REF_HUE_BITS  = 9;
	localparam int CFG_DATA_BITS = 9;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CMP_BITS      = 16;
	localparam int Q4_SHIFT      = 4;

	localparam int OUT_DATA_BITS = ((HUE_BITS + SAT_BITS + VAL_BITS + 7) / 8) * 8;
	localparam int OUT_USER_BITS = CLS_BITS + 1;

	localparam int HUE_SCALE  = 960;
	localparam int SAT_SCALE  = 1600;
	localparam int VAL_CAP    = 100;
	localparam int WIN_NEAR   = 20;
	localparam int WIN_FAR    = 70;
	localparam int HUE_FULL   = 360;

	localparam logic signed [HUE_BITS-1:0] HUE_GRAY      = -14'sd16;
	localparam logic signed [HUE_BITS-1:0] HUE_OFS_GREEN = 14'sd1920;
	localparam logic signed [HUE_BITS-1:0] HUE_OFS_BLUE  = 14'sd3840;
	localparam logic signed [HUE_BITS-1:0] HUE_MIN_Q4    = -14'sd960;
	localparam logic signed [HUE_BITS-1:0] HUE_MAX_Q4    = 14'sd4800;
	localparam logic signed [CMP_BITS-1:0] RED_WRAP_Q4   =
		CMP_BITS'((HUE_FULL - WIN_NEAR) * 16);

	localparam int DIV_LANES = 2;
	localparam int LANE_HUE  = 0;
	localparam int LANE_SAT  = 1;

	typedef enum logic [CLS_BITS-1:0] {
		CLS_NONE   = 3'd0,
		CLS_WHITE  = 3'd1,
		CLS_BLACK  = 3'd2,
		CLS_GREEN  = 3'd3,
		CLS_RED    = 3'd4,
		CLS_BLUE   = 3'd5,
		CLS_YELLOW = 3'd6
	} cls_t;

	typedef enum logic [1:0] {
		SEL_RED   = 2'd0,
		SEL_GREEN = 2'd1,
		SEL_BLUE  = 2'd2
	} sel_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SAT_WHITE  = 3'd0,
		REG_VAL_BLACK  = 3'd1,
		REG_HUE_GREEN  = 3'd2,
		REG_HUE_RED    = 3'd3,
		REG_HUE_BLUE   = 3'd4,
		REG_HUE_YELLOW = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [REF_SAT_BITS-1:0] white_sat;
		logic [REF_SAT_BITS-1:0] black_val;
		logic [REF_HUE_BITS-1:0] green_hue;
		logic [REF_HUE_BITS-1:0] red_hue;
		logic [REF_HUE_BITS-1:0] blue_hue;
		logic [REF_HUE_BITS-1:0] yellow_hue;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		white_sat:  7'd20,
		black_val:  7'd0,
		green_hue:  9'd120,
		red_hue:    9'd0,
		blue_hue:   9'd210,
		yellow_hue: 9'd50
	};

	// per-sample flags that ride along the divider
	typedef struct packed {
		sel_t                sel;
		logic                neg;
		logic                absent;
		logic                zero;
		logic [VAL_BITS-1:0] val;
	} side_t;

	localparam int SIDE_BITS = $bits(side_t);

	// (reference + offset) in sixteenths, signed
	function automatic logic signed [CMP_BITS-1:0] q4_units(
		input logic [REF_HUE_BITS-1:0] ref_v,
		input int                      ofs
	);
		return ($signed({{(CMP_BITS - REF_HUE_BITS){1'b0}}, ref_v}) + CMP_BITS'(ofs))
			<<< Q4_SHIFT;
	endfunction

endpackage

/* rtl/rhcc_prep.sv */
// Front end: channel max/min, chroma, hue difference and divider numerators.
// Three pipeline stages; depends on rhcc_pkg.
module rhcc_prep #(
	parameter int RAW_BITS = rhcc_pkg::RAW_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [RAW_BITS-1:0]                    red,
	input  logic [RAW_BITS-1:0]                    green,
	input  logic [RAW_BITS-1:0]                    blue,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [RAW_BITS+rhcc_pkg::QUO_BITS-1:0] hue_num,
	output logic [RAW_BITS+rhcc_pkg::QUO_BITS-1:0] sat_num,
	output logic [RAW_BITS-1:0]                    hue_den,
	output logic [RAW_BITS-1:0]                    sat_den,
	output rhcc_pkg::side_t                        side
);
	import rhcc_pkg::*;

	localparam int NUM_BITS = RAW_BITS + QUO_BITS;

	logic                       en1, en2, en3;
	logic                       vld_s1, vld_s2, vld_s3;

	sel_t                       sel_c;
	logic [RAW_BITS-1:0]        mx_c, mn_c;
	logic signed [RAW_BITS:0]   d_c;

	sel_t                       sel_s1;
	logic [RAW_BITS-1:0]        mx_s1, mn_s1;
	logic signed [RAW_BITS:0]   d_s1;
	logic signed [RAW_BITS:0]   dneg;

	logic [RAW_BITS-1:0]        c_s2, dabs_s2, mx_s2;
	side_t                      side_s2;

	logic [NUM_BITS-1:0]        hue_num_s3, sat_num_s3;
	logic [RAW_BITS-1:0]        hue_den_s3, sat_den_s3;
	side_t                      side_s3;

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	// max with red-green-blue tie order, and the difference that goes with it
	always_comb begin
		if (red >= green && red >= blue) begin
			sel_c = SEL_RED;
			mx_c  = red;
			d_c   = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= blue) begin
			sel_c = SEL_GREEN;
			mx_c  = green;
			d_c   = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sel_c = SEL_BLUE;
			mx_c  = blue;
			d_c   = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		mn_c = (red <= green) ? red : green;
		if (blue < mn_c) begin
			mn_c = blue;
		end
	end

	assign dneg = -d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sel_s1 <= sel_c;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			d_s1   <= d_c;
		end
		if (en2) begin
			c_s2           <= mx_s1 - mn_s1;
			dabs_s2        <= d_s1[RAW_BITS] ? dneg[RAW_BITS-1:0] : d_s1[RAW_BITS-1:0];
			mx_s2          <= mx_s1;
			side_s2.sel    <= sel_s1;
			side_s2.neg    <= d_s1[RAW_BITS];
			side_s2.absent <= (mx_s1 == mn_s1);
			side_s2.zero   <= (mx_s1 == '0);
			side_s2.val    <= (mx_s1 > RAW_BITS'(VAL_CAP)) ? VAL_BITS'(VAL_CAP)
				: mx_s1[VAL_BITS-1:0];
		end
		if (en3) begin
			hue_num_s3 <= NUM_BITS'(dabs_s2) * NUM_BITS'(HUE_SCALE);
			sat_num_s3 <= NUM_BITS'(c_s2) * NUM_BITS'(SAT_SCALE);
			hue_den_s3 <= c_s2;
			sat_den_s3 <= mx_s2;
			side_s3    <= side_s2;
		end
	end

	assign out_valid = vld_s3;
	assign hue_num   = hue_num_s3;
	assign sat_num   = sat_num_s3;
	assign hue_den   = hue_den_s3;
	assign sat_den   = sat_den_s3;
	assign side      = side_s3;

endmodule

/* rtl/rhcc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Quotient must fit QUO_BITS; depends on rhcc_pkg for defaults.
module rhcc_div #(
	parameter int DEN_BITS  = rhcc_pkg::RAW_BITS_DEF,
	parameter int QUO_BITS  = rhcc_pkg::QUO_BITS,
	parameter int LANES     = rhcc_pkg::DIV_LANES,
	parameter int SIDE_BITS = rhcc_pkg::SIDE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [DEN_BITS+QUO_BITS-1:0] num [LANES],
	input  logic [DEN_BITS-1:0]          den [LANES],
	input  logic [SIDE_BITS-1:0]         side_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [QUO_BITS-1:0]          quo [LANES],
	output logic [SIDE_BITS-1:0]         side_out
);
	import rhcc_pkg::*;

	localparam int NW = DEN_BITS + QUO_BITS;

	logic                 vld_s  [QUO_BITS+1];
	logic                 en     [QUO_BITS+2];
	logic [NW-1:0]        rem_s  [QUO_BITS][LANES];
	logic [DEN_BITS-1:0]  den_s  [QUO_BITS][LANES];
	logic [QUO_BITS-1:0]  quo_s  [QUO_BITS+1][LANES];
	logic [SIDE_BITS-1:0] side_s [QUO_BITS+1];

	assign vld_s[0]         = in_valid;
	assign side_s[0]        = side_in;
	assign en[QUO_BITS+1]   = out_ready;
	assign en[0]            = en[1];
	assign in_ready         = en[0];

	for (genvar l = 0; l < LANES; l++) begin : g_in
		assign rem_s[0][l] = num[l];
		assign den_s[0][l] = den[l];
		assign quo_s[0][l] = '0;
		assign quo[l]      = quo_s[QUO_BITS][l];
	end

	for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
		localparam int B = QUO_BITS - k;

		assign en[k] = !vld_s[k] || en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) side_s[k] <= side_s[k-1];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [NW-1:0] shd;
			logic          ge;

			assign shd = NW'(den_s[k-1][l]) << B;
			assign ge  = rem_s[k-1][l] >= shd;

			always_ff @(posedge clk) begin
				if (en[k]) quo_s[k][l] <= quo_s[k-1][l] | (QUO_BITS'(ge) << B);
			end

			if (k < QUO_BITS) begin : g_rem
				always_ff @(posedge clk) begin
					if (en[k]) begin
						rem_s[k][l] <= ge ? rem_s[k-1][l] - shd : rem_s[k-1][l];
						den_s[k][l] <= den_s[k-1][l];
					end
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_BITS];
	assign side_out  = side_s[QUO_BITS];

endmodule

/* rtl/rhcc_class.sv */
// Back end: signed hue assembly, saturation fixup, then color classification.
// Two stages, the second is the output register; depends on rhcc_pkg.
module rhcc_class (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rhcc_pkg::QUO_BITS-1:0]        hue_quo,
	input  logic [rhcc_pkg::QUO_BITS-1:0]        sat_quo,
	input  rhcc_pkg::side_t                      side,
	input  rhcc_pkg::cfg_t                       cfg,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output rhcc_pkg::cls_t                       color_class,
	output logic signed [rhcc_pkg::HUE_BITS-1:0] hue_q4,
	output logic                                 hue_absent,
	output logic [rhcc_pkg::SAT_BITS-1:0]        sat_q4,
	output logic [rhcc_pkg::VAL_BITS-1:0]        value_level
);
	import rhcc_pkg::*;

	logic                       en1, en2;
	logic                       vld_s1, vld_s2;

	logic signed [HUE_BITS-1:0] hmag, hsg, hofs, hue_c;

	logic signed [HUE_BITS-1:0] hue_s1;
	logic                       absent_s1;
	logic [SAT_BITS-1:0]        sat_s1;
	logic [VAL_BITS-1:0]        val_s1;

	logic signed [CMP_BITS-1:0] hx, sx;
	logic                       is_white, is_green, is_black, is_red, is_blue, is_yellow;
	cls_t                       cls_c;

	cls_t                       cls_s2;
	logic signed [HUE_BITS-1:0] hue_s2;
	logic                       absent_s2;
	logic [SAT_BITS-1:0]        sat_s2;
	logic [VAL_BITS-1:0]        val_s2;

	assign en2      = !vld_s2 || out_ready;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	assign hmag = $signed(HUE_BITS'(hue_quo));
	assign hsg  = side.neg ? -hmag : hmag;

	always_comb begin
		case (side.sel)
			SEL_RED:   hofs = '0;
			SEL_GREEN: hofs = HUE_OFS_GREEN;
			SEL_BLUE:  hofs = HUE_OFS_BLUE;
			default:   hofs = '0;
		endcase
	end

	assign hue_c = side.absent ? HUE_GRAY : hsg + hofs;

	assign hx = CMP_BITS'(hue_s1);
	assign sx = $signed({{(CMP_BITS - SAT_BITS){1'b0}}, sat_s1});

	assign is_white  = (q4_units({2'b00, cfg.white_sat}, -WIN_NEAR) < sx)
		&& (sx < q4_units({2'b00, cfg.white_sat}, WIN_NEAR));
	assign is_green  = (q4_units(cfg.green_hue, -WIN_NEAR) < hx)
		&& (hx < q4_units(cfg.green_hue, WIN_FAR));
	assign is_black  = {1'b0, val_s1} < ({1'b0, cfg.black_val} + (VAL_BITS+1)'(WIN_NEAR));
	assign is_red    = (hx < q4_units(cfg.red_hue, WIN_NEAR)) || (RED_WRAP_Q4 < hx);
	assign is_blue   = (q4_units(cfg.blue_hue, -WIN_NEAR) < hx)
		&& (hx < q4_units(cfg.blue_hue, WIN_NEAR));
	assign is_yellow = (q4_units(cfg.yellow_hue, -WIN_NEAR) < hx)
		&& (hx < q4_units(cfg.yellow_hue, WIN_NEAR));

	always_comb begin
		if (is_white) begin
			cls_c = CLS_WHITE;
		end else if (is_green) begin
			cls_c = is_black ? CLS_BLACK : CLS_GREEN;
		end else if (is_red) begin
			cls_c = CLS_RED;
		end else if (is_blue) begin
			cls_c = CLS_BLUE;
		end else if (is_yellow) begin
			cls_c = CLS_YELLOW;
		end else begin
			cls_c = CLS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			hue_s1    <= hue_c;
			absent_s1 <= side.absent;
			sat_s1    <= side.zero ? '0 : SAT_BITS'(sat_quo);
			val_s1    <= side.val;
		end
		if (en2) begin
			cls_s2    <= cls_c;
			hue_s2    <= hue_s1;
			absent_s2 <= absent_s1;
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
		end
	end

	assign out_valid   = vld_s2;
	assign color_class = cls_s2;
	assign hue_q4      = hue_s2;
	assign hue_absent  = absent_s2;
	assign sat_q4      = sat_s2;
	assign value_level = val_s2;

endmodule

/* rtl/rgb_hsv_color_classifier_unit.sv */
// RGB to HSV color classifier: top level with reference registers.
// Depends on rhcc_pkg, rhcc_prep, rhcc_div, rhcc_class and the defines header.
//
// Input stream s_axis: one RGB sample per word; red, green, blue packed from
// bit 0 up, RAW_BITS each. Output stream m_axis: one result word per sample,
// hue/saturation/value in tdata and class plus no-hue flag in tuser.
// Reference registers are written through cfg_we/cfg_idx/cfg_data; write them
// only while no sample is in flight. Indexes above the last register are ignored.
// Three front-end stages, one divider stage per quotient bit (11), and two
// back-end stages. Hue and saturation share the divider stages as two lanes.
// Throughput is one sample per cycle while m_axis_tready is high.
// Reset clears all pipeline valids and loads the reference defaults.
// When m_axis_tready is low, the held result stays on the output and the
// pipeline keeps accepting samples into empty stages; s_axis_tready drops
// only once every stage holds a sample.
`include "rgb_hsv_color_classifier_unit_defines.svh"

module rgb_hsv_color_classifier_unit #(
	parameter int RAW_BITS = rhcc_pkg::RAW_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// red_raw, green_raw, blue_raw
	input  logic [((3*RAW_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// hue_q4, sat_q4, value_level
	output logic [rhcc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
	// color_class, hue_absent
	output logic [rhcc_pkg::OUT_USER_BITS-1:0]  m_axis_tuser,
	input  logic                                cfg_we,
	input  logic [rhcc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [rhcc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import rhcc_pkg::*;

	localparam int NUM_BITS = RAW_BITS + QUO_BITS;

	cfg_t                       cfg_q;

	logic [RAW_BITS-1:0]        red_raw, green_raw, blue_raw;

	logic                       prep_valid, prep_ready;
	logic [NUM_BITS-1:0]        hue_num, sat_num;
	logic [RAW_BITS-1:0]        hue_den, sat_den;
	side_t                      prep_side;

	logic [NUM_BITS-1:0]        num_a [DIV_LANES];
	logic [RAW_BITS-1:0]        den_a [DIV_LANES];
	logic [QUO_BITS-1:0]        quo_a [DIV_LANES];
	logic [SIDE_BITS-1:0]       div_side;
	logic                       div_valid, div_ready;

	cls_t                       color_class;
	logic signed [HUE_BITS-1:0] hue_q4;
	logic                       hue_absent;
	logic [SAT_BITS-1:0]        sat_q4;
	logic [VAL_BITS-1:0]        value_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_SAT_WHITE:  cfg_q.white_sat  <= cfg_data[REF_SAT_BITS-1:0];
				REG_VAL_BLACK:  cfg_q.black_val  <= cfg_data[REF_SAT_BITS-1:0];
				REG_HUE_GREEN:  cfg_q.green_hue  <= cfg_data[REF_HUE_BITS-1:0];
				REG_HUE_RED:    cfg_q.red_hue    <= cfg_data[REF_HUE_BITS-1:0];
				REG_HUE_BLUE:   cfg_q.blue_hue   <= cfg_data[REF_HUE_BITS-1:0];
				REG_HUE_YELLOW: cfg_q.yellow_hue <= cfg_data[REF_HUE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign red_raw   = s_axis_tdata[RAW_BITS-1:0];
	assign green_raw = s_axis_tdata[2*RAW_BITS-1:RAW_BITS];
	assign blue_raw  = s_axis_tdata[3*RAW_BITS-1:2*RAW_BITS];

	rhcc_prep #(
		.RAW_BITS (RAW_BITS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.red       (red_raw),
		.green     (green_raw),
		.blue      (blue_raw),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.hue_num   (hue_num),
		.sat_num   (sat_num),
		.hue_den   (hue_den),
		.sat_den   (sat_den),
		.side      (prep_side)
	);

	assign num_a[LANE_HUE] = hue_num;
	assign num_a[LANE_SAT] = sat_num;
	assign den_a[LANE_HUE] = hue_den;
	assign den_a[LANE_SAT] = sat_den;

	rhcc_div #(
		.DEN_BITS  (RAW_BITS),
		.QUO_BITS  (QUO_BITS),
		.LANES     (DIV_LANES),
		.SIDE_BITS (SIDE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.num       (num_a),
		.den       (den_a),
		.side_in   (prep_side),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.quo       (quo_a),
		.side_out  (div_side)
	);

	rhcc_class u_class (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.in_ready    (div_ready),
		.hue_quo     (quo_a[LANE_HUE]),
		.sat_quo     (quo_a[LANE_SAT]),
		.side        (side_t'(div_side)),
		.cfg         (cfg_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.color_class (color_class),
		.hue_q4      (hue_q4),
		.hue_absent  (hue_absent),
		.sat_q4      (sat_q4),
		.value_level (value_level)
	);

	assign m_axis_tdata = OUT_DATA_BITS'({value_level, sat_q4, hue_q4});
	assign m_axis_tuser = {hue_absent, color_class};

	`RHCC_ASSERT_IMP(a_gray_word, m_axis_tvalid && hue_absent, hue_q4 == HUE_GRAY && sat_q4 == '0, "gray word with hue or saturation set")
	`RHCC_ASSERT_IMP(a_sat_range, m_axis_tvalid, sat_q4 <= SAT_BITS'(SAT_SCALE), "saturation above full scale")
	`RHCC_ASSERT_IMP(a_hue_range, m_axis_tvalid && !hue_absent, hue_q4 >= HUE_MIN_Q4 && hue_q4 <= HUE_MAX_Q4, "hue out of range")
	`RHCC_ASSERT_IMP(a_ready_free, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input blocked with output free")
	`RHCC_ASSERT_NXT(a_full_hold, !s_axis_tready, m_axis_tvalid, "pipeline full but output empty next cycle")

endmodule
